[hw/rtl/alr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alr_pkg: shared types and helpers of the antialiased line rasteriser
// Item structs, sequencer state, handshake groups and colour helpers.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int PANEL_DIM = 64;
  localparam int CoordW    = 6;
  localparam int DimW      = 7;
  localparam int PixW      = 8;
  localparam int ChanW     = 8;
  localparam int RgbW      = 3 * ChanW;
  localparam int FracW     = 16;
  localparam int QuoW      = 16;
  localparam int AccW      = 24;
  localparam int CntW      = 7;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [15:0]       line_color;
    logic              double_wide;
  } in_item_t;

  typedef struct packed {
    logic signed [PixW-1:0] first_x;
    logic signed [PixW-1:0] first_y;
    logic [RgbW-1:0]        first_rgb;
    logic                   second_valid;
    logic signed [PixW-1:0] second_x;
    logic signed [PixW-1:0] second_y;
    logic [RgbW-1:0]        second_rgb;
    logic                   last_write;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_WU_END,
    ST_WU_WAIT,
    ST_WU_STEP,
    ST_DONE
  } seq_state_e;

  typedef enum logic [0:0] {
    CFG_PANEL_WIDTH  = 1'b0,
    CFG_PANEL_HEIGHT = 1'b1
  } cfg_idx_e;

  // core towards output stage
  typedef struct packed {
    logic cand_valid;
    logic end_valid;
  } seq_req_t;

  // output stage towards core
  typedef struct packed {
    logic cand_ready;
    logic end_ready;
  } seq_gnt_t;

  function automatic logic [RgbW-1:0] expand565(input logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  // halve each channel, requantise to RGB565, expand again
  function automatic logic [RgbW-1:0] halve_rgb(input logic [RgbW-1:0] rgb);
    logic [15:0] c;
    c = {1'b0, rgb[23:20], 1'b0, rgb[15:11], 1'b0, rgb[7:4]};
    return expand565(c);
  endfunction

  function automatic logic [CoordW-1:0] sat_coord(input logic [CoordW-1:0] v);
    if ({1'b0, v} > DimW'(PANEL_DIM - 1)) begin
      return CoordW'(PANEL_DIM - 1);
    end
    return v;
  endfunction

  function automatic logic [DimW-1:0] cap_dim(input logic [DimW-1:0] v);
    if (v > DimW'(PANEL_DIM)) begin
      return DimW'(PANEL_DIM);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/alr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alr_div: iterative slope divider
// Restoring division of (num << 16) by den, one quotient bit per cycle.
// Requires num < den, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module alr_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [alr_pkg::CoordW-1:0]   num_i,
  input  wire  [alr_pkg::CoordW-1:0]   den_i,
  output logic                         done_o,
  output logic [alr_pkg::QuoW-1:0]     quo_o
);
  import alr_pkg::*;

  localparam int StepW = $clog2(QuoW + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [CoordW-1:0] den_q, den_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [CoordW:0]   rem2;
  logic [CoordW:0]   diff;
  logic              ge;

  always_comb begin
    rem2 = {rem_q, 1'b0};
    diff = rem2 - {1'b0, den_q};
    ge   = rem2 >= {1'b0, den_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      done_d = 1'b0;
      cnt_d  = StepW'(QuoW);
      rem_d  = num_i;
      den_d  = den_i;
    end else if (run_q) begin
      rem_d = ge ? diff[CoordW-1:0] : rem2[CoordW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[hw/rtl/alr_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alr_core: line sequencer
// Classifies a line command; unless output stalls, walks solid lines one pixel
// pair per cycle, Wu lines one column per cycle after iterative slope division.
// ----------------------------------------------------------------------------
module alr_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  alr_pkg::in_item_t             in_item_i,
  input  wire  [alr_pkg::DimW-1:0]      panel_w_i,
  input  wire  [alr_pkg::DimW-1:0]      panel_h_i,
  output alr_pkg::seq_req_t             req_o,
  input  alr_pkg::seq_gnt_t             gnt_i,
  output alr_pkg::out_item_t            cand_o
);
  import alr_pkg::*;

  seq_state_e state_q, state_d;

  // command classification
  logic [CoordW-1:0] x0, y0, x1, y1, dx, dy;
  logic              straight, vertical, horizontal, accept;
  logic              diag_fwd, diag_up, steep;
  logic [CoordW-1:0] a0, b0, a1, b1, ma0, mb0, ma1, mb1;
  logic [CoordW-1:0] dmaj, dmin;
  logic [RgbW-1:0]   base_rgb;

  // solid line walker
  logic [RgbW-1:0]        color_q;
  logic                   dbl_q;
  logic signed [PixW-1:0] cur_x_q, cur_y_q;
  logic [CntW-1:0]        cnt_q;
  logic                   step_x_q, y_up_q, y_dn_q, off_x_q;

  // Wu walker
  logic                   steep_q, neg_q;
  logic [CoordW-1:0]      u0_q, v0_q, u1_q, v1_q;
  logic [AccW-1:0]        acc_q, slope_q, slope;
  logic [DimW-1:0]        u_q, stop_q, major_w, minor_h;

  logic                   div_done;
  logic [QuoW-1:0]        quo;

  logic signed [PixW-1:0] row, row1, u_pix;
  logic                   row_vis, wu_fin;
  logic [ChanW-1:0]       frac;
  logic [RgbW-1:0]        hi_rgb, lo_rgb;
  logic [2*ChanW-1:0]     prod;
  logic [ChanW-1:0]       chan, low;

  always_comb begin
    x0 = sat_coord(in_item_i.start_x);
    y0 = sat_coord(in_item_i.start_y);
    x1 = sat_coord(in_item_i.end_x);
    y1 = sat_coord(in_item_i.end_y);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    vertical   = (dx == '0);
    horizontal = !vertical && (dy == '0);
    straight   = vertical || (dy == '0) || (dx == dy);
    diag_fwd   = (x0 <= x1);
    diag_up    = diag_fwd ? (y1 > y0) : (y0 > y1);
    steep      = dy > dx;
    a0 = steep ? y0 : x0;
    b0 = steep ? x0 : y0;
    a1 = steep ? y1 : x1;
    b1 = steep ? x1 : y1;
    // order along the major axis
    ma0 = (a0 > a1) ? a1 : a0;
    mb0 = (a0 > a1) ? b1 : b0;
    ma1 = (a0 > a1) ? a0 : a1;
    mb1 = (a0 > a1) ? b0 : b1;
    dmaj = ma1 - ma0;
    dmin = (mb1 >= mb0) ? mb1 - mb0 : mb0 - mb1;
    base_rgb = expand565(in_item_i.line_color);
    accept   = (state_q == ST_IDLE) && in_valid_i;
  end

  alr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && !straight),
    .num_i   (dmin),
    .den_i   (dmaj),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    slope   = neg_q ? (AccW'(0) - AccW'(quo)) : AccW'(quo);
    major_w = steep_q ? panel_h_i : panel_w_i;
    minor_h = steep_q ? panel_w_i : panel_h_i;
    row     = acc_q[AccW-1 -: PixW];
    row1    = row + PixW'(1);
    u_pix   = PixW'(u_q);
    row_vis = !row[PixW-1] && (row[DimW-1:0] < minor_h);
    wu_fin  = u_q >= stop_q;
    frac    = acc_q[FracW-1 -: ChanW];
  end

  // split each channel by the fractional byte
  always_comb begin
    hi_rgb = '0;
    lo_rgb = '0;
    prod   = '0;
    chan   = '0;
    low    = '0;
    for (int c = 0; c < 3; c++) begin
      chan = color_q[c*ChanW +: ChanW];
      prod = chan * frac;
      low  = prod[2*ChanW-1 -: ChanW];
      lo_rgb[c*ChanW +: ChanW] = low;
      hi_rgb[c*ChanW +: ChanW] = chan - low;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = straight ? ST_LINE : ST_WU_END;
        end
      end
      ST_LINE: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_WU_END: begin
        if (gnt_i.cand_ready) begin
          state_d = ST_WU_WAIT;
        end
      end
      ST_WU_WAIT: begin
        if (div_done) begin
          state_d = ST_WU_STEP;
        end
      end
      ST_WU_STEP: begin
        if (wu_fin) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (gnt_i.end_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    req_o      = '0;
    cand_o     = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_LINE: begin
        req_o.cand_valid  = (cnt_q != '0);
        cand_o.first_x    = cur_x_q;
        cand_o.first_y    = cur_y_q;
        cand_o.first_rgb  = color_q;
        if (dbl_q) begin
          cand_o.second_valid = 1'b1;
          cand_o.second_x     = cur_x_q + PixW'(off_x_q);
          cand_o.second_y     = cur_y_q + PixW'(!off_x_q);
          cand_o.second_rgb   = color_q;
        end
      end
      ST_WU_END: begin
        req_o.cand_valid    = 1'b1;
        cand_o.first_x      = PixW'(steep_q ? v0_q : u0_q);
        cand_o.first_y      = PixW'(steep_q ? u0_q : v0_q);
        cand_o.first_rgb    = color_q;
        cand_o.second_valid = 1'b1;
        cand_o.second_x     = PixW'(steep_q ? v1_q : u1_q);
        cand_o.second_y     = PixW'(steep_q ? u1_q : v1_q);
        cand_o.second_rgb   = color_q;
      end
      ST_WU_WAIT: ;
      ST_WU_STEP: begin
        req_o.cand_valid    = !wu_fin && row_vis;
        cand_o.first_x      = steep_q ? row : u_pix;
        cand_o.first_y      = steep_q ? u_pix : row;
        cand_o.first_rgb    = hi_rgb;
        cand_o.second_valid = 1'b1;
        cand_o.second_x     = steep_q ? row1 : u_pix;
        cand_o.second_y     = steep_q ? u_pix : row1;
        cand_o.second_rgb   = lo_rgb;
      end
      ST_DONE: req_o.end_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers of the line
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dbl_q    <= in_item_i.double_wide;
          color_q  <= (straight && in_item_i.double_wide) ? halve_rgb(base_rgb) : base_rgb;
          steep_q  <= steep;
          u0_q     <= ma0;
          v0_q     <= mb0;
          u1_q     <= ma1;
          v1_q     <= mb1;
          neg_q    <= mb1 < mb0;
          if (vertical) begin
            cnt_q    <= CntW'(dy);
            cur_x_q  <= PixW'(x0);
            cur_y_q  <= PixW'((y0 < y1) ? y0 : y1);
            step_x_q <= 1'b0;
            y_up_q   <= 1'b1;
            y_dn_q   <= 1'b0;
            off_x_q  <= 1'b1;
          end else if (horizontal) begin
            cnt_q    <= CntW'(dx);
            cur_x_q  <= PixW'((x0 < x1) ? x0 : x1);
            cur_y_q  <= PixW'(y0);
            step_x_q <= 1'b1;
            y_up_q   <= 1'b0;
            y_dn_q   <= 1'b0;
            off_x_q  <= 1'b0;
          end else begin
            cnt_q    <= CntW'(dx) + CntW'(1);
            cur_x_q  <= PixW'(diag_fwd ? x0 : x1);
            cur_y_q  <= PixW'(diag_fwd ? y0 : y1);
            step_x_q <= 1'b1;
            y_up_q   <= diag_up;
            y_dn_q   <= !diag_up;
            off_x_q  <= 1'b1;
          end
        end
      end
      ST_LINE: begin
        if (cnt_q != '0 && gnt_i.cand_ready) begin
          cnt_q   <= cnt_q - CntW'(1);
          cur_x_q <= cur_x_q + PixW'(step_x_q);
          if (y_up_q) begin
            cur_y_q <= cur_y_q + PixW'(1);
          end else if (y_dn_q) begin
            cur_y_q <= cur_y_q - PixW'(1);
          end
        end
      end
      ST_WU_WAIT: begin
        if (div_done) begin
          slope_q <= slope;
          acc_q   <= AccW'({v0_q, {FracW{1'b0}}}) + slope;
          u_q     <= DimW'(u0_q) + DimW'(1);
          stop_q  <= ({1'b0, u1_q} >= major_w) ? major_w : DimW'(u1_q);
        end
      end
      ST_WU_STEP: begin
        // advance past skipped rows at once, visible ones once taken
        if (!wu_fin && (!row_vis || gnt_i.cand_ready)) begin
          acc_q <= acc_q + slope_q;
          u_q   <= u_q + DimW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/antialiased_line_rasterizer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit: antialiased line rasteriser
// Turns one line command into a stream of pixel-pair items, marking the last.
// ----------------------------------------------------------------------------
// Solid lines: one pixel pair per cycle while the output does not stall.
// Wu lines: the 16-step slope division runs beside the endpoint item, then
//   one column per cycle, skipped rows too, while the output does not stall.
// The last item leaves in the cycle after the sequencer ends; one item is held
//   back so that the last one can be marked. One command at a time.
// Reset clears the sequencer and output stage; panel size resets to 64 x 32.
module antialiased_line_rasterizer_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  alr_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output alr_pkg::out_item_t           out_item_o,
  input  wire                          cfg_we_i,
  input  wire  [0:0]                   cfg_idx_i,
  input  wire  [alr_pkg::DimW-1:0]     cfg_data_i
);
  import alr_pkg::*;

  logic [DimW-1:0] panel_w_q, panel_h_q;
  seq_req_t        req;
  seq_gnt_t        gnt;
  out_item_t       cand;

  out_item_t       hold_q, hold_d, out_q, out_d;
  logic            hold_valid_q, hold_valid_d, out_valid_q, out_valid_d;
  logic            out_free, cand_fire, end_fire, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_w_q <= DimW'(PANEL_DIM);
      panel_h_q <= DimW'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PANEL_WIDTH:  panel_w_q <= cap_dim(cfg_data_i);
        CFG_PANEL_HEIGHT: panel_h_q <= cap_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  alr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .panel_w_i  (panel_w_q),
    .panel_h_i  (panel_h_q),
    .req_o      (req),
    .gnt_i      (gnt),
    .cand_o     (cand)
  );

  // hold one item back; release it marked last when the command ends
  always_comb begin
    out_free       = !out_valid_q || out_ready_i;
    gnt.cand_ready = !hold_valid_q || out_free;
    gnt.end_ready  = !hold_valid_q || out_free;
    cand_fire      = req.cand_valid && gnt.cand_ready;
    end_fire       = req.end_valid && gnt.end_ready;
    push           = hold_valid_q && (cand_fire || end_fire);

    out_d            = out_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    if (push) begin
      out_d            = hold_q;
      out_d.last_write = end_fire;
      out_valid_d      = 1'b1;
    end

    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    if (cand_fire) begin
      hold_d       = cand;
      hold_valid_d = 1'b1;
    end else if (end_fire) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // an idle block has nothing held back
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !hold_valid_q)
    else $error("item held while idle");

  a_req_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.cand_valid && req.end_valid))
    else $error("pixel and end request together");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.second_valid) |->
      (out_item_o.second_rgb == '0 && out_item_o.second_x == '0))
    else $error("unused second pixel not zero");

  a_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_fire |=> !hold_valid_q)
    else $error("held item left after end of command");

endmodule
`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: antialiased line rasteriser unit
// Drives line commands through the valid/ready input, predicts every pixel-pair
// item from its own model of solid and Wu stepping, and checks each output item
// in order, with random idling on both sides, a long output hold-off, and panel
// size changes between phases.
// ----------------------------------------------------------------------------
module testbench;
  import alr_pkg::*;

  localparam int SettleCycles = 120;
  localparam int HoldOffCycles = 400;

  typedef enum int {
    LINE_VERTICAL,
    LINE_HORIZONTAL,
    LINE_DIAGONAL,
    LINE_POINT,
    LINE_ANY
  } line_kind_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       line_valid = 1'b0;
  logic       line_ready;
  in_item_t   line_item = '0;
  logic       pix_valid;
  logic       pix_ready = 1'b0;
  out_item_t  pix_item;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_idx = CFG_PANEL_WIDTH;
  logic [DimW-1:0] cfg_data = '0;

  out_item_t pending_pixels[$];
  int        panel_w = 64;
  int        panel_h = 32;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_off = 0;
  int        error_count = 0;

  antialiased_line_rasterizer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (line_valid),
    .in_ready_o  (line_ready),
    .in_item_i   (line_item),
    .out_valid_o (pix_valid),
    .out_ready_i (pix_ready),
    .out_item_o  (pix_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic logic [23:0] rgb888(logic [15:0] c);
    logic [7:0] r, g, b;
    r = {c[15:11], 3'b000} | 8'(c[15:11] >> 2);
    g = {c[10:5], 2'b00} | 8'(c[10:5] >> 4);
    b = {c[4:0], 3'b000} | 8'(c[4:0] >> 2);
    return {r, g, b};
  endfunction

  function automatic logic [23:0] half_rgb(logic [23:0] rgb);
    logic [7:0] r, g, b;
    r = rgb[23:16] >> 1;
    g = rgb[15:8] >> 1;
    b = rgb[7:0] >> 1;
    return rgb888({r[7:3], g[7:2], b[7:3]});
  endfunction

  function automatic void queue_pair(int ax, int ay, logic [23:0] argb, bit two,
                                     int bx, int by, logic [23:0] brgb);
    out_item_t p;
    p.first_x      = ax[7:0];
    p.first_y      = ay[7:0];
    p.first_rgb    = argb;
    p.second_valid = two;
    p.second_x     = two ? bx[7:0] : 8'd0;
    p.second_y     = two ? by[7:0] : 8'd0;
    p.second_rgb   = two ? brgb : 24'd0;
    p.last_write   = 1'b0;
    pending_pixels.push_back(p);
  endfunction

  function automatic void predict_line(in_item_t it);
    int x0, y0, x1, y1, dx, dy, t, w, h, u, acc, slope, row, cnt, i;
    int sx, sy, ux, uy, ox, oy, f, r, g, b, lr, lg, lb, first_new;
    bit steep;
    logic [23:0] rgb, hi, lo;
    out_item_t tail;
    x0 = it.start_x;
    y0 = it.start_y;
    x1 = it.end_x;
    y1 = it.end_y;
    dx = x1 > x0 ? x1 - x0 : x0 - x1;
    dy = y1 > y0 ? y1 - y0 : y0 - y1;
    rgb = rgb888(it.line_color);
    first_new = pending_pixels.size();
    if (dx == 0 || dy == 0 || dx == dy) begin
      if (it.double_wide) begin
        rgb = half_rgb(rgb);
      end
      if (dx == 0) begin
        cnt = dy; sx = x0; sy = y0 < y1 ? y0 : y1; ux = 0; uy = 1; ox = 1; oy = 0;
      end else if (dy == 0) begin
        cnt = dx; sx = x0 < x1 ? x0 : x1; sy = y0; ux = 1; uy = 0; ox = 0; oy = 1;
      end else begin
        cnt = dx + 1; ux = 1; ox = 1; oy = 0;
        if (x0 <= x1) begin
          sx = x0; sy = y0; uy = y1 > y0 ? 1 : -1;
        end else begin
          sx = x1; sy = y1; uy = y0 > y1 ? 1 : -1;
        end
      end
      for (i = 0; i < cnt; i++) begin
        queue_pair(sx + ux * i, sy + uy * i, rgb, it.double_wide,
                   sx + ux * i + ox, sy + uy * i + oy, rgb);
      end
    end else begin
      steep = dy > dx;
      if (steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      w = steep ? panel_h : panel_w;
      h = steep ? panel_w : panel_h;
      // endpoints go out unclipped, as one pair
      if (steep) begin
        queue_pair(y0, x0, rgb, 1'b1, y1, x1, rgb);
      end else begin
        queue_pair(x0, y0, rgb, 1'b1, x1, y1, rgb);
      end
      slope = ((y1 - y0) * 65536) / (x1 - x0);
      acc = y0 * 65536 + slope;
      if (x1 >= w) begin
        x1 = w;
      end
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      for (u = x0 + 1; u <= x1 - 1; u++) begin
        row = acc >>> 16;
        if (row >= 0 && row < h) begin
          f = (acc >> 8) & 255;
          lr = (r * f) >> 8;
          lg = (g * f) >> 8;
          lb = (b * f) >> 8;
          hi = {8'(r - lr), 8'(g - lg), 8'(b - lb)};
          lo = {8'(lr), 8'(lg), 8'(lb)};
          if (steep) begin
            queue_pair(row, u, hi, 1'b1, row + 1, u, lo);
          end else begin
            queue_pair(u, row, hi, 1'b1, u, row + 1, lo);
          end
        end
        acc = acc + slope;
      end
    end
    if (pending_pixels.size() > first_new) begin
      tail = pending_pixels.pop_back();
      tail.last_write = 1'b1;
      pending_pixels.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // entered anywhere, leaves just after the accepting edge
  task automatic send_line(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    line_valid <= 1'b1;
    line_item  <= it;
    do @(posedge clk); while (!line_ready);
    predict_line(it);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    line_valid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    // a command with no pixels may still be in flight
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_panel(input int w, input int h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PANEL_WIDTH;
    cfg_data <= DimW'(w);
    panel_w = (w & 127) > PANEL_DIM ? PANEL_DIM : (w & 127);
    @(negedge clk);
    cfg_idx  <= CFG_PANEL_HEIGHT;
    cfg_data <= DimW'(h);
    panel_h = (h & 127) > PANEL_DIM ? PANEL_DIM : (h & 127);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_line(int sx, int sy, int ex, int ey,
                                         logic [15:0] colour, bit dbl);
    in_item_t it;
    it.start_x     = CoordW'(sx);
    it.start_y     = CoordW'(sy);
    it.end_x       = CoordW'(ex);
    it.end_y       = CoordW'(ey);
    it.line_color  = colour;
    it.double_wide = dbl;
    return it;
  endfunction

  function automatic in_item_t random_line();
    in_item_t it;
    line_kind_e kind;
    int draw, d;
    it.start_x     = CoordW'($urandom_range(0, 63));
    it.start_y     = CoordW'($urandom_range(0, 63));
    it.end_x       = CoordW'($urandom_range(0, 63));
    it.end_y       = CoordW'($urandom_range(0, 63));
    it.line_color  = 16'($urandom_range(0, 65535));
    it.double_wide = 1'($urandom_range(0, 1));
    draw = $urandom_range(0, 9);
    kind = draw < LINE_ANY ? line_kind_e'(draw) : LINE_ANY;
    case (kind)
      LINE_VERTICAL: begin
        it.end_x = it.start_x;
      end
      LINE_HORIZONTAL: begin
        it.end_y = it.start_y;
      end
      LINE_DIAGONAL: begin
        d = it.end_x > it.start_x ? it.end_x - it.start_x : it.start_x - it.end_x;
        if ($urandom_range(0, 1)) begin
          it.start_y = CoordW'($urandom_range(0, 63 - d));
          it.end_y   = CoordW'(it.start_y + d);
        end else begin
          it.start_y = CoordW'($urandom_range(d, 63));
          it.end_y   = CoordW'(it.start_y - d);
        end
      end
      LINE_POINT: begin
        it.end_x = it.start_x;
        it.end_y = it.start_y;
      end
      default: begin
      end
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_off > 0) begin
      pix_ready <= 1'b0;
      hold_off--;
    end else begin
      pix_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_pixels
    out_item_t want;
    if (rst_n && pix_valid && pix_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel item: expected none, got %h", $time, pix_item);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("first_x", 24'(want.first_x), 24'(pix_item.first_x));
        check_field("first_y", 24'(want.first_y), 24'(pix_item.first_y));
        check_field("first_rgb", want.first_rgb, pix_item.first_rgb);
        check_field("second_valid", 24'(want.second_valid), 24'(pix_item.second_valid));
        check_field("second_x", 24'(want.second_x), 24'(pix_item.second_x));
        check_field("second_y", 24'(want.second_y), 24'(pix_item.second_y));
        check_field("second_rgb", want.second_rgb, pix_item.second_rgb);
        check_field("last_write", 24'(want.last_write), 24'(pix_item.last_write));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_lines();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_line(make_line(5, 5, 5, 5, 16'hFFFF, 1'b0));
    send_line(make_line(63, 63, 63, 63, 16'hFFFF, 1'b1));
    send_line(make_line(0, 0, 0, 63, 16'hFFFF, 1'b0));
    send_line(make_line(63, 63, 63, 0, 16'h0000, 1'b1));
    send_line(make_line(63, 0, 0, 0, 16'hF800, 1'b1));
    send_line(make_line(0, 63, 63, 63, 16'h07E0, 1'b1));
    send_line(make_line(0, 0, 63, 63, 16'h001F, 1'b0));
    send_line(make_line(63, 0, 0, 63, 16'hFFFF, 1'b1));
    send_line(make_line(0, 63, 63, 0, 16'h8410, 1'b0));
    send_line(make_line(0, 0, 63, 1, 16'hFFFF, 1'b0));
    send_line(make_line(63, 31, 0, 0, 16'hFFFF, 1'b1));
    // steep line runs past the 32-row extent and gets clamped
    send_line(make_line(0, 0, 10, 63, 16'hABCD, 1'b0));
    // every inner column lands below the panel and is skipped
    send_line(make_line(2, 40, 60, 62, 16'h5555, 1'b0));
    send_line(make_line(1, 0, 2, 2, 16'h1234, 1'b1));
    send_line(make_line(10, 20, 13, 21, 16'hFEDC, 1'b0));
    drain_pixels();
  endtask

  task automatic test_panel_extremes();
    write_panel(1, 1);
    send_line(make_line(0, 0, 63, 5, 16'hFFFF, 1'b0));
    send_line(make_line(0, 0, 5, 63, 16'h7BEF, 1'b0));
    drain_pixels();
    write_panel(127, 0);
    send_line(make_line(0, 0, 63, 62, 16'hC618, 1'b0));
    send_line(make_line(3, 0, 9, 63, 16'h39E7, 1'b1));
    drain_pixels();
    write_panel(64, 64);
    send_line(make_line(0, 1, 63, 62, 16'hFFFF, 1'b0));
    send_line(make_line(62, 0, 0, 63, 16'h4A69, 1'b0));
    drain_pixels();
  endtask

  task automatic test_random_lines(input int send_pct, input int recv_pct,
                                   input int count);
    int w, h;
    w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(16, 64);
    h = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(16, 64);
    write_panel(w, h);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      send_line(random_line());
    end
    drain_pixels();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    @(posedge clk);
    hold_off = HoldOffCycles;
    // keep offering long lines while the output is blocked
    send_line(make_line(0, 0, 0, 63, 16'h1F1F, 1'b1));
    send_line(make_line(0, 0, 63, 20, 16'hE0E0, 1'b0));
    send_line(make_line(63, 10, 0, 10, 16'h5AA5, 1'b0));
    send_line(make_line(0, 63, 63, 0, 16'hA55A, 1'b1));
    send_line(random_line());
    drain_pixels();
  endtask

  task automatic test_pause_and_resume();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (3) send_line(random_line());
    // hold the input until every pixel has been seen
    @(negedge clk);
    line_valid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) send_line(random_line());
    drain_pixels();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_lines();
    test_panel_extremes();
    test_random_lines(35, 71, 26);
    test_random_lines(71, 35, 26);
    test_random_lines(0, 0, 26);
    test_output_hold_off();
    test_pause_and_resume();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
